// File: hdl/crp_pkg.sv
`timescale 1ns / 1ps

package crp_pkg;

	localparam logic [1:0] KIND_VICTIM = 2'd0;
	localparam logic [1:0] KIND_PIN    = 2'd1;
	localparam logic [1:0] KIND_UNPIN  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP_START,
		ST_SWEEP,
		ST_REM_PREV,
		ST_REM_NEXT,
		ST_APPEND,
		ST_RESP
	} state_t;

endpackage

// File: hdl/clock_replacement_policy.sv
`timescale 1ns / 1ps

// channel   handshake             payload                                    dir
// request   req_valid, req_stall  kind, frame                                in
// response  rsp_valid, rsp_stall  victim_found, victim_frame, tracked_count  out
//
// one request at a time, every access goes through the single frame memory
// (one write and one registered read per cycle)
// a victim request on an empty set responds without a sweep
// a victim sweep clears the reference bit of each referenced frame it passes and wraps from tail to head
// after reset a clearing pass over every frame entry runs with req_stall high
// a finished response waits in the output register while the next request runs

module clock_replacement_policy
	import crp_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] kind,
	input  logic [5:0] frame,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic       victim_found,
	output logic [5:0] victim_frame,
	output logic [6:0] tracked_count
);

	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);

	typedef struct packed {
		logic          present;
		logic          refd;
		logic [FW-1:0] nxt;
		logic [FW-1:0] prv;
	} entry_t;

	entry_t        mem [NUM_FRAMES];
	entry_t        rd_q;
	logic          wr_en;
	logic [FW-1:0] wr_addr;
	entry_t        wr_data;
	logic [FW-1:0] rd_addr;

	state_t        state_q, state_d;
	logic [FW-1:0] clr_q, clr_d;
	logic [FW-1:0] head_q, head_d;
	logic [FW-1:0] tail_q, tail_d;
	logic [FW-1:0] hand_q, hand_d;
	logic          past_q, past_d;
	logic [CW-1:0] count_q, count_d;

	logic [1:0]    op_q, op_d;
	logic [FW-1:0] cur_q, cur_d;
	logic          found_q, found_d;
	logic [FW-1:0] victim_q, victim_d;
	entry_t        ent_q, ent_d;
	logic          is_tail_q, is_tail_d;
	logic [FW-1:0] link_q, link_d;

	logic          rsp_valid_q;
	logic          rsp_found_q;
	logic [5:0]    rsp_frame_q;
	logic [6:0]    rsp_count_q;
	logic          load_rsp;
	logic          do_remove;

	logic          in_range;
	logic [FW-1:0] fidx;
	logic [FW-1:0] sweep_addr;

	assign in_range   = 32'(frame) < NUM_FRAMES;
	assign fidx       = FW'(frame);
	assign sweep_addr = past_q ? head_q : hand_q;

	// frame memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			hand_q      <= '0;
			past_q      <= 1'b1;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			clr_q   <= clr_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			hand_q  <= hand_d;
			past_q  <= past_d;
			count_q <= count_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		cur_q     <= cur_d;
		found_q   <= found_d;
		victim_q  <= victim_d;
		ent_q     <= ent_d;
		is_tail_q <= is_tail_d;
		link_q    <= link_d;
		if (load_rsp) begin
			rsp_found_q <= found_q;
			rsp_frame_q <= 6'(victim_q);
			rsp_count_q <= 7'(count_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		head_d    = head_q;
		tail_d    = tail_q;
		hand_d    = hand_q;
		past_d    = past_q;
		count_d   = count_q;
		op_d      = op_q;
		cur_d     = cur_q;
		found_d   = found_q;
		victim_d  = victim_q;
		ent_d     = ent_q;
		is_tail_d = is_tail_q;
		link_d    = link_q;
		wr_en     = 1'b0;
		wr_addr   = cur_q;
		wr_data   = rd_q;
		rd_addr   = cur_q;
		req_stall = 1'b1;
		load_rsp  = 1'b0;
		do_remove = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				clr_d   = clr_q + FW'(1);
				if (clr_q == FW'(NUM_FRAMES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					op_d     = kind;
					cur_d    = fidx;
					found_d  = 1'b0;
					victim_d = '0;
					rd_addr  = fidx;
					case (kind)
						KIND_VICTIM: begin
							state_d = (count_q == '0) ? ST_RESP : ST_SWEEP_START;
						end
						KIND_PIN, KIND_UNPIN: begin
							state_d = in_range ? ST_LOOKUP : ST_RESP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				if (op_q == KIND_PIN) begin
					if (rd_q.present) begin
						do_remove = 1'b1;
					end else begin
						state_d = ST_RESP;
					end
				end else if (rd_q.present) begin
					wr_en        = 1'b1;
					wr_data.refd = 1'b1;
					state_d      = ST_RESP;
				end else begin
					wr_en           = 1'b1;
					wr_data         = '0;
					wr_data.present = 1'b1;
					wr_data.refd    = 1'b1;
					tail_d          = cur_q;
					count_d         = count_q + CW'(1);
					if (count_q == '0) begin
						head_d  = cur_q;
						state_d = ST_RESP;
					end else begin
						wr_data.prv = tail_q;
						rd_addr     = tail_q;
						link_d      = tail_q;
						state_d     = ST_APPEND;
					end
				end
			end
			ST_SWEEP_START: begin
				hand_d  = sweep_addr;
				past_d  = 1'b0;
				cur_d   = sweep_addr;
				rd_addr = sweep_addr;
				state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (!rd_q.refd) begin
					found_d   = 1'b1;
					victim_d  = cur_q;
					do_remove = 1'b1;
				end else begin
					wr_en        = 1'b1;
					wr_data.refd = 1'b0;
					if (hand_q == tail_q) begin
						past_d  = 1'b1;
						state_d = ST_SWEEP_START;
					end else begin
						hand_d  = rd_q.nxt;
						cur_d   = rd_q.nxt;
						rd_addr = rd_q.nxt;
					end
				end
			end
			ST_REM_PREV: begin
				wr_en       = 1'b1;
				wr_addr     = ent_q.prv;
				wr_data.nxt = ent_q.nxt;
				if (!is_tail_q) begin
					rd_addr = ent_q.nxt;
					state_d = ST_REM_NEXT;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_REM_NEXT: begin
				wr_en       = 1'b1;
				wr_addr     = ent_q.nxt;
				wr_data.prv = ent_q.prv;
				state_d     = ST_RESP;
			end
			ST_APPEND: begin
				wr_en       = 1'b1;
				wr_addr     = link_q;
				wr_data.nxt = cur_q;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// unlink cur_q, its entry is in rd_q
		if (do_remove) begin
			ent_d     = rd_q;
			is_tail_d = (cur_q == tail_q);
			if (!past_q && hand_q == cur_q) begin
				if (hand_q == tail_q) begin
					past_d = 1'b1;
				end else begin
					hand_d = rd_q.nxt;
				end
			end
			wr_en   = 1'b1;
			wr_addr = cur_q;
			wr_data = '0;
			count_d = count_q - CW'(1);
			if (cur_q == head_q) begin
				head_d = rd_q.nxt;
			end
			if (cur_q == tail_q) begin
				tail_d = rd_q.prv;
			end
			if (cur_q != head_q) begin
				rd_addr = rd_q.prv;
				state_d = ST_REM_PREV;
			end else if (cur_q != tail_q) begin
				rd_addr = rd_q.nxt;
				state_d = ST_REM_NEXT;
			end else begin
				state_d = ST_RESP;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign victim_found  = rsp_found_q;
	assign victim_frame  = rsp_frame_q;
	assign tracked_count = rsp_count_q;

endmodule

// File: hdl/crp_checker.sv
`timescale 1ns / 1ps

module crp_checker #(
	parameter int NUM_FRAMES = 64
) (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic       victim_found,
	input logic [5:0] victim_frame,
	input logic [6:0] tracked_count
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(victim_found)
			&& $stable(victim_frame) && $stable(tracked_count))
		else $error("stalled response changed");

	// one request in flight
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	a_no_victim_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !victim_found |-> victim_frame == 6'd0)
		else $error("victim frame set without victim");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && victim_found |-> 32'(tracked_count) < NUM_FRAMES)
		else $error("count too large after eviction");

endmodule

bind clock_replacement_policy crp_checker #(.NUM_FRAMES(NUM_FRAMES)) u_crp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_stall     (req_stall),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.victim_found  (victim_found),
	.victim_frame  (victim_frame),
	.tracked_count (tracked_count)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench
	import crp_pkg::*;
();

	localparam int FRAMES = 64;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 200;
	localparam int PRINT_CAP = 40;

	typedef enum {FLOW_FREE, FLOW_COIN, FLOW_CHOKE, FLOW_BEAT} flow_t;

	typedef struct packed {
		logic       found;
		logic [5:0] frame;
		logic [6:0] held;
	} outcome_t;

	class replacer_board;
		bit         listed[FRAMES];
		bit         ref_bit[FRAMES];
		logic [5:0] succ[FRAMES];
		logic [5:0] pred[FRAMES];
		logic [5:0] head, tail, hand;
		bit         hand_off;
		int         held;
		outcome_t   pending[$];
		int         mismatches, checked, evictions, empty_sweeps, peak_held;

		function new();
			foreach (listed[i]) begin
				listed[i] = 0;
				ref_bit[i] = 0;
				succ[i] = '0;
				pred[i] = '0;
			end
			head = '0;
			tail = '0;
			hand = '0;
			hand_off = 1;
			held = 0;
			mismatches = 0;
			checked = 0;
			evictions = 0;
			empty_sweeps = 0;
			peak_held = 0;
		endfunction

		function void step_hand();
			if (hand_off)
				return;
			if (hand == tail)
				hand_off = 1;
			else
				hand = succ[hand];
		endfunction

		function void drop_frame(logic [5:0] f);
			if (!listed[f])
				return;
			if (!hand_off && hand == f)
				step_hand();
			if (f == head)
				head = succ[f];
			else
				succ[pred[f]] = succ[f];
			if (f == tail)
				tail = pred[f];
			else
				pred[succ[f]] = pred[f];
			listed[f] = 0;
			ref_bit[f] = 0;
			held--;
		endfunction

		function void list_frame(logic [5:0] f);
			if (listed[f]) begin
				ref_bit[f] = 1;
				return;
			end
			if (held == 0) begin
				head = f;
			end else begin
				succ[tail] = f;
				pred[f] = tail;
			end
			tail = f;
			listed[f] = 1;
			ref_bit[f] = 1;
			held++;
		endfunction

		// predict the response of one accepted request
		function void note_request(logic [1:0] k, logic [5:0] f);
			outcome_t o;
			o = '0;
			case (k)
			KIND_VICTIM: begin
				if (held == 0)
					empty_sweeps++;
				for (int g = 0; held > 0 && g <= 2 * FRAMES + 2; g++) begin
					if (hand_off) begin
						hand = head;
						hand_off = 0;
					end
					if (!ref_bit[hand]) begin
						o.found = 1'b1;
						o.frame = hand;
						evictions++;
						drop_frame(hand);
						break;
					end
					ref_bit[hand] = 0;
					step_hand();
				end
			end
			KIND_PIN: begin
				drop_frame(f);
			end
			KIND_UNPIN: begin
				list_frame(f);
			end
			default: begin
			end
			endcase
			o.held = 7'(held);
			if (held > peak_held)
				peak_held = held;
			pending.insert(pending.size(), o);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic found, logic [5:0] fr, logic [6:0] cnt);
			outcome_t want;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected response found=%0d frame=%0d count=%0d",
					found, fr, cnt));
				return;
			end
			want = pending.pop_front();
			if (found !== want.found)
				report($sformatf("victim_found %0d, expected %0d", found, want.found));
			if (fr !== want.frame)
				report($sformatf("victim_frame %0d, expected %0d", fr, want.frame));
			if (cnt !== want.held)
				report($sformatf("tracked_count %0d, expected %0d", cnt, want.held));
		endtask

		function logic [5:0] pick_frame(bit want_listed);
			logic [5:0] pool[$];
			foreach (listed[i])
				if (listed[i] == want_listed)
					pool.insert(pool.size(), 6'(i));
			if (pool.size() == 0)
				return 6'($urandom_range(0, FRAMES - 1));
			return pool[$urandom_range(0, pool.size() - 1)];
		endfunction

		function logic [5:0] hand_frame();
			if (hand_off || held == 0)
				return pick_frame(1);
			return hand;
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [1:0] kind = KIND_VICTIM;
	logic [5:0] frame = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic       victim_found;
	logic [5:0] victim_frame;
	logic [6:0] tracked_count;

	replacer_board board;
	int    burst_left = 0;
	int    accepted = 0;
	bit    draining = 0;
	flow_t stall_mode = FLOW_FREE;
	int    stall_left = 0;

	clock_replacement_policy #(.NUM_FRAMES(FRAMES)) dut (.*);

	always #4 clk = ~clk;

	// sender: bursts of requests with random gaps between them
	task automatic issue(logic [1:0] k, logic [5:0] f);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) begin
				@(negedge clk);
				req_valid <= 1'b0;
				kind <= 2'($urandom);
				frame <= 6'($urandom);
			end
			burst_left = $urandom_range(1, 4) == 1 ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
		burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		kind <= k;
		frame <= f;
		do @(posedge clk); while (req_stall !== 1'b0);
		board.note_request(k, f);
		accepted++;
	endtask

	task automatic random_phase(int n, int pct_unpin, int pct_pin, int pct_victim);
		int         roll;
		logic [1:0] k;
		logic [5:0] f;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			f = 6'($urandom);
			if (roll < pct_unpin) begin
				k = KIND_UNPIN;
				roll = $urandom_range(0, 99);
				if (roll < 60)
					f = board.pick_frame(0);
				else if (roll < 85)
					f = board.pick_frame(1);
			end else if (roll < pct_unpin + pct_pin) begin
				k = KIND_PIN;
				roll = $urandom_range(0, 99);
				if (roll < 50)
					f = board.pick_frame(1);
				else if (roll < 80)
					f = board.hand_frame();
			end else if (roll < pct_unpin + pct_pin + pct_victim) begin
				k = KIND_VICTIM;
			end else begin
				k = KIND_SPARE;
			end
			issue(k, f);
		end
	endtask

	// receiver: stall pattern changes mode every so often
	always @(negedge clk) begin
		logic hold;
		if (stall_left == 0) begin
			stall_mode = flow_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 160);
		end
		stall_left--;
		case (stall_mode)
		FLOW_FREE: hold = 1'b0;
		FLOW_COIN: hold = $urandom_range(0, 1) == 1;
		FLOW_CHOKE: hold = $urandom_range(0, 7) != 0;
		default: hold = (stall_left % 4) < 2;
		endcase
		rsp_stall <= hold && !draining;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			board.check_result(victim_found, victim_frame, tracked_count);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timed out after %0d cycles with no handshake", quiet);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		board = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// empty set, unlisted pin, unused kind
		issue(KIND_VICTIM, 6'd0);
		issue(KIND_PIN, 6'd0);
		issue(KIND_SPARE, 6'd63);
		// append, re-reference, full sweep with wrap
		issue(KIND_UNPIN, 6'd0);
		issue(KIND_UNPIN, 6'd63);
		issue(KIND_UNPIN, 6'd0);
		issue(KIND_UNPIN, 6'd21);
		issue(KIND_VICTIM, 6'd63);
		issue(KIND_VICTIM, 6'd0);
		issue(KIND_VICTIM, 6'd42);
		// hand past the tail, then unpin
		issue(KIND_UNPIN, 6'd5);
		issue(KIND_UNPIN, 6'd6);
		issue(KIND_VICTIM, 6'd0);
		// pin the frame under the hand
		issue(KIND_PIN, 6'd6);
		issue(KIND_UNPIN, 6'd7);
		issue(KIND_UNPIN, 6'd8);
		issue(KIND_UNPIN, 6'd42);
		issue(KIND_VICTIM, 6'd0);
		issue(KIND_PIN, 6'd8);
		issue(KIND_PIN, 6'd63);
		issue(KIND_VICTIM, 6'd21);
		issue(KIND_VICTIM, 6'd0);
		issue(KIND_VICTIM, 6'd0);

		random_phase(100, 90, 4, 5);
		random_phase(120, 40, 25, 33);
		random_phase(100, 10, 20, 69);
		random_phase(100, 90, 4, 5);
		random_phase(120, 34, 33, 30);
		random_phase(80, 5, 5, 89);
		random_phase(100, 90, 4, 5);
		random_phase(130, 40, 25, 33);
		random_phase(100, 10, 20, 69);

		@(negedge clk);
		req_valid <= 1'b0;
		draining = 1;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests, %0d responses checked, %0d mismatching fields",
			accepted, board.checked, board.mismatches);
		$display("%0d evictions, %0d victim requests on an empty set, peak of %0d frames",
			board.evictions, board.empty_sweeps, board.peak_held);
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
